// ----- hw/rtl/pid_position_step_unit_defines.svh -----
// Assertion macros shared by the checker of pid_position_step_unit.
// Needs nothing else; each macro samples on the rising clock edge and is off in reset.
`ifndef PID_POSITION_STEP_UNIT_DEFINES_SVH
`define PID_POSITION_STEP_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid_position_step_unit: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid_position_step_unit: next-cycle check failed");

`endif

// ----- hw/rtl/pps_pkg.sv -----
// Types, widths and constants of the PID position step unit.
// Used by the serial multiplier, the serial divider and the top level.
`default_nettype none

package pps_pkg;

    localparam int ANG_W     = 9;
    localparam int GAIN_W    = 16;
    localparam int MS_W      = 16;
    localparam int DRV_W     = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ERR_W     = ANG_W + 1;
    localparam int SUM_W     = GAIN_W + 1;

    // Serial multiplier: one multiplier bit per cycle.
    localparam int MC_W      = ANG_W + GAIN_W;
    localparam int MR_W      = 16;
    localparam int PROD_W    = MC_W + MR_W;
    localparam int MUL_CNT_W = $clog2(MR_W + 1);

    // Serial restoring divider: one quotient bit per cycle.
    localparam int DVD_W     = PROD_W;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam int PM_W      = MC_W;
    localparam int INC_W     = 32;
    localparam int DM_W      = 35;
    localparam int INTEG_W   = 32;

    localparam int FULL_TURN   = 360;
    localparam int DRIVE_LIMIT = 100;
    localparam int MS_PER_S    = 1000;
    localparam int TOL_RESET   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef logic [ANG_W-1:0]            angle_t;
    typedef logic signed [GAIN_W-1:0]    move_t;
    typedef logic [MS_W-1:0]             ms_t;
    typedef logic signed [DRV_W-1:0]     drive_t;
    typedef logic [CFG_W-1:0]            cfg_data_t;
    typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;

    typedef struct packed {
        logic              start;
        logic [MC_W-1:0]   mcand;
        logic [MR_W-1:0]   mplier;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [DVD_W-1:0]  quotient;
        logic [DVS_W-1:0]  remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pid_position_step_unit.sv -----
// PID position step unit: one start or tick beat in, one drive/done beat out.
// A tick uses the shared bit-serial multiplier (five products per tick) and the
// restoring divider (one quotient for the integral step and one for the derivative,
// skipped when elapsed_ms is 0); a start uses the divider alone, for the angle wrap.
// One item is worked at a time; a finished result waits in the output register
// while the next item is taken.
// Depends on pps_pkg, pps_ser_mul and pps_ser_div.
`default_nettype none

module pid_position_step_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  pps_pkg::angle_t    angle,
    input  pps_pkg::move_t     move_delta,
    input  pps_pkg::ms_t       elapsed_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output pps_pkg::drive_t    drive,
    output logic               done_res,
    input  logic               cfg_we,
    input  pps_pkg::cfg_idx_t  cfg_index,
    input  pps_pkg::cfg_data_t cfg_data
);
    import pps_pkg::*;

    localparam int PS_W    = PM_W + 1;
    localparam int DS_W    = DM_W + 1;
    localparam int PD_W    = DS_W + 1;
    localparam int TOT_W   = PD_W + 1;
    localparam int INCS_W  = INC_W + 1;
    localparam int ISUM_W  = INTEG_W + 2;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DT   = 4'd1;
    localparam logic [3:0] ST_MP   = 4'd2;
    localparam logic [3:0] ST_MI1  = 4'd3;
    localparam logic [3:0] ST_MI2  = 4'd4;
    localparam logic [3:0] ST_MD1  = 4'd5;
    localparam logic [3:0] ST_MD2  = 4'd6;
    localparam logic [3:0] ST_DI   = 4'd7;
    localparam logic [3:0] ST_DD   = 4'd8;
    localparam logic [3:0] ST_INT  = 4'd9;
    localparam logic [3:0] ST_SUM  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    // configuration
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [ANG_W-1:0]  tol_reg;

    // control and controller state
    logic [3:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [ANG_W-1:0]   target_reg, target_next;
    logic [ANG_W-1:0]   prev_reg, prev_next;
    logic [INTEG_W-1:0] integ_reg, integ_next;

    // per-item payload
    logic [ANG_W-1:0]   angle_reg, angle_next;
    logic [MS_W-1:0]    dt_reg, dt_next;
    logic [ANG_W-1:0]   err_mag_reg, err_mag_next;
    logic               err_neg_reg, err_neg_next;
    logic [ANG_W-1:0]   dpos_mag_reg, dpos_mag_next;
    logic               dpos_neg_reg, dpos_neg_next;
    logic               s_neg_reg, s_neg_next;
    logic [PM_W-1:0]    p_mag_reg, p_mag_next;
    logic [INC_W-1:0]   inc_mag_reg, inc_mag_next;
    logic [DM_W-1:0]    d_mag_reg, d_mag_next;
    logic [PD_W-1:0]    pd_reg, pd_next;
    logic [DRV_W-1:0]   drive_res_reg, drive_res_next;
    logic [DRV_W-1:0]   out_drive_reg, out_drive_next;
    logic               out_done_reg, out_done_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                   accept;
    logic [ERR_W-1:0]       in_err, in_err_abs;
    logic [ERR_W-1:0]       in_dpos, in_dpos_abs;
    logic [SUM_W-1:0]       in_sum, in_sum_abs;
    logic [GAIN_W-1:0]      gp_mag, gi_mag, gd_mag;
    logic [ANG_W-1:0]       rem_turn, new_target;
    logic [INCS_W-1:0]      inc_u, inc_s;
    logic [ISUM_W-1:0]      isum;
    logic [INTEG_W-1:0]     integ_sat;
    logic [PS_W-1:0]        p_u, p_s;
    logic [DS_W-1:0]        d_u, d_s;
    logic [PD_W-1:0]        pd_sum;
    logic signed [TOT_W-1:0] total, lim_hi, lim_lo;
    logic [DRV_W-1:0]       drive_sat;
    logic [ERR_W-1:0]       out_err, out_err_abs;
    logic                   out_done;

    pps_ser_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    pps_ser_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // input-side differences, magnitudes and signs
    assign in_err      = {1'b0, target_reg} - {1'b0, angle};
    assign in_err_abs  = in_err[ERR_W-1] ? (~in_err + 1'b1) : in_err;
    assign in_dpos     = {1'b0, angle} - {1'b0, prev_reg};
    assign in_dpos_abs = in_dpos[ERR_W-1] ? (~in_dpos + 1'b1) : in_dpos;
    assign in_sum      = {{(SUM_W - ANG_W){1'b0}}, angle} + {move_delta[GAIN_W-1], move_delta};
    assign in_sum_abs  = in_sum[SUM_W-1] ? (~in_sum + 1'b1) : in_sum;

    assign gp_mag = gain_p_reg[GAIN_W-1] ? (~gain_p_reg + 1'b1) : gain_p_reg;
    assign gi_mag = gain_i_reg[GAIN_W-1] ? (~gain_i_reg + 1'b1) : gain_i_reg;
    assign gd_mag = gain_d_reg[GAIN_W-1] ? (~gain_d_reg + 1'b1) : gain_d_reg;

    // wrap into one turn; a negative sum with a nonzero remainder folds back
    assign rem_turn   = div_rsp.remainder[ANG_W-1:0];
    assign new_target = (s_neg_reg && (rem_turn != '0)) ?
                        (ANG_W'(FULL_TURN) - rem_turn) : rem_turn;

    // integral step, saturated to the 32-bit signed range
    assign inc_u = {1'b0, inc_mag_reg};
    assign inc_s = (gain_i_reg[GAIN_W-1] ^ err_neg_reg) ? (~inc_u + 1'b1) : inc_u;
    assign isum  = {{2{integ_reg[INTEG_W-1]}}, integ_reg} + {inc_s[INCS_W-1], inc_s};

    always_comb
    begin
        if (isum[ISUM_W-1] && (isum[ISUM_W-2:INTEG_W-1] != 2'b11))
        begin
            integ_sat = {1'b1, {(INTEG_W - 1){1'b0}}};
        end
        else if (!isum[ISUM_W-1] && (isum[ISUM_W-2:INTEG_W-1] != 2'b00))
        begin
            integ_sat = {1'b0, {(INTEG_W - 1){1'b1}}};
        end
        else
        begin
            integ_sat = isum[INTEG_W-1:0];
        end
    end

    assign p_u    = {1'b0, p_mag_reg};
    assign p_s    = (gain_p_reg[GAIN_W-1] ^ err_neg_reg) ? (~p_u + 1'b1) : p_u;
    assign d_u    = {1'b0, d_mag_reg};
    assign d_s    = (gain_d_reg[GAIN_W-1] ^ dpos_neg_reg) ? (~d_u + 1'b1) : d_u;
    assign pd_sum = {{(PD_W - PS_W){p_s[PS_W-1]}}, p_s} + {d_s[DS_W-1], d_s};

    assign total  = $signed({pd_reg[PD_W-1], pd_reg}
                    + {{(TOT_W - INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg});
    assign lim_hi = TOT_W'(DRIVE_LIMIT);
    assign lim_lo = -TOT_W'(DRIVE_LIMIT);

    always_comb
    begin
        if (total > lim_hi)
        begin
            drive_sat = DRV_W'(DRIVE_LIMIT);
        end
        else if (total < lim_lo)
        begin
            drive_sat = DRV_W'(-DRIVE_LIMIT);
        end
        else
        begin
            drive_sat = total[DRV_W-1:0];
        end
    end

    assign out_err     = {1'b0, target_reg} - {1'b0, angle_reg};
    assign out_err_abs = out_err[ERR_W-1] ? (~out_err + 1'b1) : out_err;
    assign out_done    = (out_err_abs <= {1'b0, tol_reg});

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        target_next    = target_reg;
        prev_next      = prev_reg;
        integ_next     = integ_reg;
        angle_next     = angle_reg;
        dt_next        = dt_reg;
        err_mag_next   = err_mag_reg;
        err_neg_next   = err_neg_reg;
        dpos_mag_next  = dpos_mag_reg;
        dpos_neg_next  = dpos_neg_reg;
        s_neg_next     = s_neg_reg;
        p_mag_next     = p_mag_reg;
        inc_mag_next   = inc_mag_reg;
        d_mag_next     = d_mag_reg;
        pd_next        = pd_reg;
        drive_res_next = drive_res_reg;
        out_drive_next = out_drive_reg;
        out_done_next  = out_done_reg;
        mul_req        = '0;
        div_req        = '0;

        // drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    angle_next    = angle;
                    dt_next       = elapsed_ms;
                    err_mag_next  = in_err_abs[ANG_W-1:0];
                    err_neg_next  = in_err[ERR_W-1];
                    dpos_mag_next = in_dpos_abs[ANG_W-1:0];
                    dpos_neg_next = in_dpos[ERR_W-1];
                    s_neg_next    = in_sum[SUM_W-1];
                    if (kind == KIND_TICK)
                    begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = {{(MC_W - ANG_W){1'b0}}, in_err_abs[ANG_W-1:0]};
                        mul_req.mplier = gp_mag;
                        state_next     = ST_MP;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {{(DVD_W - SUM_W){1'b0}}, in_sum_abs};
                        div_req.divisor  = DVS_W'(FULL_TURN);
                        state_next       = ST_DT;
                    end
                end
            end
            ST_DT:
            begin
                if (!div_rsp.busy)
                begin
                    target_next    = new_target;
                    prev_next      = angle_reg;
                    integ_next     = '0;
                    drive_res_next = '0;
                    state_next     = ST_OUT;
                end
            end
            ST_MP:
            begin
                if (!mul_rsp.busy)
                begin
                    p_mag_next     = mul_rsp.product[PM_W-1:0];
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = {{(MC_W - ANG_W){1'b0}}, err_mag_reg};
                    mul_req.mplier = gi_mag;
                    state_next     = ST_MI1;
                end
            end
            ST_MI1:
            begin
                if (!mul_rsp.busy)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = mul_rsp.product[MC_W-1:0];
                    mul_req.mplier = dt_reg;
                    state_next     = ST_MI2;
                end
            end
            ST_MI2:
            begin
                if (!mul_rsp.busy)
                begin
                    // integral divide runs alongside the derivative products
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_rsp.product;
                    div_req.divisor  = DVS_W'(MS_PER_S);
                    mul_req.start    = 1'b1;
                    mul_req.mcand    = {{(MC_W - ANG_W){1'b0}}, dpos_mag_reg};
                    mul_req.mplier   = gd_mag;
                    state_next       = ST_MD1;
                end
            end
            ST_MD1:
            begin
                if (!mul_rsp.busy)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = mul_rsp.product[MC_W-1:0];
                    mul_req.mplier = MR_W'(MS_PER_S);
                    state_next     = ST_MD2;
                end
            end
            ST_MD2:
            begin
                if (!mul_rsp.busy)
                begin
                    state_next = ST_DI;
                end
            end
            ST_DI:
            begin
                if (!div_rsp.busy)
                begin
                    inc_mag_next = div_rsp.quotient[INC_W-1:0];
                    if (dt_reg == '0)
                    begin
                        d_mag_next = '0;
                        state_next = ST_INT;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = mul_rsp.product;
                        div_req.divisor  = dt_reg;
                        state_next       = ST_DD;
                    end
                end
            end
            ST_DD:
            begin
                if (!div_rsp.busy)
                begin
                    d_mag_next = div_rsp.quotient[DM_W-1:0];
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                integ_next = integ_sat;
                pd_next    = pd_sum;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                drive_res_next = drive_sat;
                prev_next      = angle_reg;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_drive_next = drive_res_reg;
                    out_done_next  = out_done;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            tol_reg    <= ANG_W'(TOL_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:    gain_p_reg <= cfg_data;
                REG_GAIN_I:    gain_i_reg <= cfg_data;
                REG_GAIN_D:    gain_d_reg <= cfg_data;
                REG_TOLERANCE: tol_reg    <= cfg_data[ANG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            prev_reg      <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            prev_reg      <= prev_next;
            integ_reg     <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg     <= angle_next;
        dt_reg        <= dt_next;
        err_mag_reg   <= err_mag_next;
        err_neg_reg   <= err_neg_next;
        dpos_mag_reg  <= dpos_mag_next;
        dpos_neg_reg  <= dpos_neg_next;
        s_neg_reg     <= s_neg_next;
        p_mag_reg     <= p_mag_next;
        inc_mag_reg   <= inc_mag_next;
        d_mag_reg     <= d_mag_next;
        pd_reg        <= pd_next;
        drive_res_reg <= drive_res_next;
        out_drive_reg <= out_drive_next;
        out_done_reg  <= out_done_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = out_drive_reg;
    assign done_res  = out_done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pps_ser_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pps_pkg for widths and the request/response structs.
`default_nettype none

module pps_ser_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  pps_pkg::mul_req_t req,
    output pps_pkg::mul_rsp_t rsp
);
    import pps_pkg::*;

    logic                 busy_reg, busy_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    mcand_reg, mcand_next;
    logic [MR_W-1:0]      mplier_reg, mplier_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;

    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = MUL_CNT_W'(MR_W);
            mcand_next  = {{(PROD_W - MC_W){1'b0}}, req.mcand};
            mplier_next = req.mplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand when the low multiplier bit is set
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MR_W-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign rsp.busy    = busy_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pps_ser_div.sv -----
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// Depends on pps_pkg for widths and the request/response structs.
`default_nettype none

module pps_ser_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pps_pkg::div_req_t req,
    output pps_pkg::div_rsp_t rsp
);
    import pps_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       trial;

    // remainder stays below the divisor, so the top bit of trial is the borrow
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DVD_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DVS_W])
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pps_checker.sv -----
// Port-level checker for pid_position_step_unit, attached by bind below.
// Depends on pps_pkg and the macros in pid_position_step_unit_defines.svh.
`default_nettype none

`include "pid_position_step_unit_defines.svh"

module pps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input pps_pkg::drive_t    drive,
    input logic               done_res
);
    import pps_pkg::*;

    logic in_beat;
    logic out_stall;
    logic drive_in_range;

    assign in_beat        = in_valid && in_ready;
    assign out_stall      = out_valid && !out_ready;
    assign drive_in_range = (drive <= DRV_W'(DRIVE_LIMIT)) && (drive >= -DRV_W'(DRIVE_LIMIT));

    // a stalled result beat holds its payload
    `PPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(drive) && $stable(done_res))

    // drive stays within the saturation window while out_valid is high
    `PPS_ASSERT_SAME(a_drive_range, clk, rst_n, out_valid, drive_in_range)

    // an accepted item keeps the input closed after the accept
    `PPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_beat, !in_ready ##1 !in_ready)

    // a new result only appears after work with the input closed
    `PPS_ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind pid_position_step_unit pps_checker u_pps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive      (drive),
    .done_res   (done_res)
);

`default_nettype wire

// ----- bench/pid_drive_checker.sv -----
// Checker for pid_position_step_unit: tracks register writes, predicts drive/done per beat.
// Depends on pps_pkg; instantiated by tb_top beside the unit under test.
`timescale 1ns / 100ps

module pid_drive_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               kind,
    input  pps_pkg::angle_t    angle,
    input  pps_pkg::move_t     move_delta,
    input  pps_pkg::ms_t       elapsed_ms,
    input  logic               out_valid,
    input  logic               out_ready,
    input  pps_pkg::drive_t    drive,
    input  logic               done_res,
    input  logic               cfg_we,
    input  pps_pkg::cfg_idx_t  cfg_index,
    input  pps_pkg::cfg_data_t cfg_data,
    output int                 mismatches,
    output int                 outstanding
);
    import pps_pkg::*;

    localparam longint INTEG_HI = 64'sd2147483647;
    localparam longint INTEG_LO = -INTEG_HI - 1;

    typedef struct {
        drive_t drive;
        logic   done;
    } drive_result_t;

    drive_result_t drive_due_q[$];

    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic [ANG_W-1:0]          tol_deg;
    angle_t                    aim_deg;
    angle_t                    last_deg;
    logic signed [INTEG_W-1:0] integ;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic near_aim(longint err);
        longint mag;
        mag = (err < 0) ? -err : err;
        return mag <= longint'(tol_deg);
    endfunction

    // Advance the controller state by one beat and return the result it owes.
    function automatic drive_result_t step_controller(logic k, angle_t ang, move_t delta,
                                                      ms_t dt);
        drive_result_t res;
        longint        err;
        longint        dpos;
        longint        inc;
        longint        d;
        longint        wrapped;
        if (k == KIND_START)
        begin
            wrapped = (longint'(ang) + longint'(delta)) % FULL_TURN;
            if (wrapped < 0)
                wrapped += FULL_TURN;
            aim_deg   = angle_t'(wrapped);
            last_deg  = ang;
            integ     = '0;
            res.drive = '0;
            res.done  = near_aim(longint'(aim_deg) - longint'(ang));
            return res;
        end
        // plain difference: no shortest-path wrap, angles above 359 used as given
        err  = longint'(aim_deg) - longint'(ang);
        dpos = longint'(ang) - longint'(last_deg);
        inc  = (longint'(ki) * err * longint'(dt)) / MS_PER_S;
        integ = INTEG_W'(clamp(longint'(integ) + inc, INTEG_LO, INTEG_HI));
        d = (dt == 0) ? 0 : (longint'(kd) * dpos * MS_PER_S) / longint'(dt);
        res.drive = drive_t'(clamp(longint'(kp) * err + longint'(integ) + d,
                                   -DRIVE_LIMIT, DRIVE_LIMIT));
        res.done  = near_aim(err);
        last_deg  = ang;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_result_t want;
        if (!rst_n)
        begin
            kp       = '0;
            ki       = '0;
            kd       = '0;
            tol_deg  = ANG_W'(TOL_RESET);
            aim_deg  = '0;
            last_deg = '0;
            integ    = '0;
            drive_due_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_P:    kp = cfg_data;
                    REG_GAIN_I:    ki = cfg_data;
                    REG_GAIN_D:    kd = cfg_data;
                    REG_TOLERANCE: tol_deg = cfg_data[ANG_W-1:0];
                    default:       ;
                endcase
            end
            // check the output beat first: a beat taken this edge cannot answer itself
            if (out_valid && out_ready)
            begin
                if (drive_due_q.size() == 0)
                begin
                    $error("result beat with nothing pending: drive %0d done_res %0b",
                           drive, done_res);
                    mismatches++;
                end
                else
                begin
                    want = drive_due_q.pop_front();
                    if (drive !== want.drive)
                    begin
                        $error("drive: expected %0d, actual %0d", want.drive, drive);
                        mismatches++;
                    end
                    if (done_res !== want.done)
                    begin
                        $error("done_res: expected %0b, actual %0b", want.done, done_res);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                drive_due_q.push_back(step_controller(kind, angle, move_delta, elapsed_ms));
            outstanding = drive_due_q.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the pid_position_step_unit bench: clock, reset, stimulus, stall pattern and verdict.
// Depends on pps_pkg, pid_position_step_unit and pid_drive_checker.
`timescale 1ns / 100ps

module tb_top;
    import pps_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    logic      kind;
    angle_t    angle;
    move_t     move_delta;
    ms_t       elapsed_ms;
    logic      out_valid;
    logic      out_ready;
    drive_t    drive;
    logic      done_res;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    int mismatches;
    int outstanding;
    int beats_sent;
    int pos_deg;
    int goal_deg;
    bit idle_on;
    bit hold_req;

    pid_position_step_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .angle      (angle),
        .move_delta (move_delta),
        .elapsed_ms (elapsed_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive),
        .done_res   (done_res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    pid_drive_checker drive_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .angle       (angle),
        .move_delta  (move_delta),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive       (drive),
        .done_res    (done_res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so the next beat can follow without a bubble.
    task automatic send_beat(logic k, angle_t a, move_t m, ms_t e);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        kind       = k;
        angle      = a;
        move_delta = m;
        elapsed_ms = e;
        in_valid   = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = cfg_data_t'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_config(int p, int i, int d, int tol);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_TOLERANCE, tol);
    endtask

    // Drop valid and wait until every result is back and the unit has gone quiet.
    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_gain();
        if ($urandom_range(0, 4) == 0)
            return int'(move_t'($urandom));
        return int'($urandom_range(0, 60)) - 30;
    endfunction

    function automatic ms_t pick_ms();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ms_t'($urandom);
            default: return ms_t'($urandom_range(1, 20));
        endcase
    endfunction

    // One start beat, then a run of ticks that settle toward the new target.
    task automatic random_move();
        int a;
        int delta;
        int n;
        if ($urandom_range(0, 9) == 0)
            a = $urandom_range(360, 511);
        else
            a = $urandom_range(0, 359);
        if ($urandom_range(0, 4) == 0)
            delta = int'(move_t'($urandom));
        else
            delta = int'($urandom_range(0, 720)) - 360;
        send_beat(KIND_START, angle_t'(a), move_t'(delta), ms_t'($urandom));
        pos_deg  = a;
        goal_deg = ((a + delta) % FULL_TURN + FULL_TURN) % FULL_TURN;
        n = $urandom_range(2, 12);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                a = $urandom_range(0, 511);
            else
            begin
                pos_deg = pos_deg + (goal_deg - pos_deg) / 2 + int'($urandom_range(0, 6)) - 3;
                if (pos_deg < 0)
                    pos_deg = 0;
                if (pos_deg > FULL_TURN - 1)
                    pos_deg = FULL_TURN - 1;
                a = pos_deg;
            end
            send_beat(KIND_TICK, angle_t'(a), move_t'($urandom), pick_ms());
        end
    endtask

    // Receiver: random short stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
                out_ready = 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int goal;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_START;
        angle      = '0;
        move_delta = '0;
        elapsed_ms = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_GAIN_P;
        cfg_data   = '0;
        beats_sent = 0;
        pos_deg    = 0;
        goal_deg   = 0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ticks before any start, against the reset target and reset tolerance
        send_beat(KIND_TICK, angle_t'(0), move_t'(0), ms_t'(10));
        send_beat(KIND_TICK, angle_t'(511), move_t'(-1), ms_t'(0));

        drain();
        set_config(3, 50, -2, 5);
        send_beat(KIND_START, angle_t'(0), move_t'(32767), ms_t'(0));
        send_beat(KIND_START, angle_t'(359), move_t'(-32768), ms_t'(65535));
        send_beat(KIND_START, angle_t'(511), move_t'(0), ms_t'(7));
        send_beat(KIND_START, angle_t'(10), move_t'(0), ms_t'(0));
        send_beat(KIND_TICK, angle_t'(10), move_t'(0), ms_t'(0));
        send_beat(KIND_TICK, angle_t'(0), move_t'(0), ms_t'(65535));
        send_beat(KIND_TICK, angle_t'(359), move_t'(0), ms_t'(1));
        send_beat(KIND_TICK, angle_t'(511), move_t'(0), ms_t'(1000));

        // full positive integral: push it into saturation, tolerance above a turn
        drain();
        set_config(32767, 32767, -32768, 511);
        send_beat(KIND_START, angle_t'(0), move_t'(359), ms_t'(0));
        repeat (3) send_beat(KIND_TICK, angle_t'(0), move_t'(0), ms_t'(65535));
        send_beat(KIND_TICK, angle_t'(511), move_t'(0), ms_t'(0));

        // and the negative extremes, zero tolerance
        drain();
        set_config(-32768, -32768, 32767, 0);
        send_beat(KIND_START, angle_t'(0), move_t'(359), ms_t'(0));
        repeat (3) send_beat(KIND_TICK, angle_t'(0), move_t'(0), ms_t'(65535));
        send_beat(KIND_TICK, angle_t'(359), move_t'(0), ms_t'(1));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            set_config(pick_gain(), pick_gain(), pick_gain(),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                   : $urandom_range(0, 10));
            idle_on = (phase != PHASES - 1);
            if (phase == 1)
                hold_req = 1'b1;
            goal = beats_sent + PHASE_ITEMS;
            while (beats_sent < goal)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_beat(logic'($urandom_range(0, 1)), angle_t'($urandom_range(0, 511)),
                              move_t'($urandom), ms_t'($urandom));
                else
                    random_move();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
